FILE: rtl/core/groove_timing_offset_defines.svh
// assertion macros for the groove timing offset checker
// expects clk and rst_n in the scope of each use
`ifndef GROOVE_TIMING_OFFSET_DEFINES_SVH
`define GROOVE_TIMING_OFFSET_DEFINES_SVH

// same-cycle implication, off while in reset
`define GTO_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, off while in reset
`define GTO_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/gto_pkg.sv
// shared types, constants and tables of the groove timing offset block
// no dependencies
`default_nettype none

package gto_pkg;

  localparam int NSTG          = 9;
  localparam int POS_W         = 40;
  localparam int ID_W          = 32;
  localparam int OUT_W         = 24;
  localparam int SPS_W         = 32;
  localparam int STEPS_PER_BAR = 16;
  localparam int SLOT_W        = $clog2(STEPS_PER_BAR);

  localparam logic [ID_W-1:0] HASH_MUL = 32'd2654435761;

  // reciprocals for exact floor division by constants (ceil of 2^sh / d)
  localparam int Q_DIV_SH  = 37;
  localparam logic [27:0] Q_DIV_RCP  = 28'(((64'd1 << Q_DIV_SH) + 64'd599) / 64'd600);
  localparam int P_DIV_SH  = 45;
  localparam logic [31:0] P_DIV_RCP  = 32'(((64'd1 << P_DIV_SH) + 64'd15624) / 64'd15625);
  localparam int H_MOD_SH  = 41;
  localparam logic [31:0] H_MOD_RCP  = 32'(((64'd1 << H_MOD_SH) + 64'd999) / 64'd1000);
  localparam int SW_DIV_SH = 30;
  localparam logic [25:0] SW_DIV_RCP = 26'(((64'd1 << SW_DIV_SH) + 64'd24) / 64'd25);

  typedef enum logic [2:0] {
    REG_SWING_GRID        = 3'd0,
    REG_SWING_AMOUNT      = 3'd1,
    REG_POCKET_AMOUNT     = 3'd2,
    REG_HUMANIZE_AMOUNT   = 3'd3,
    REG_QUANTIZE_GRID     = 3'd4,
    REG_QUANTIZE_STRENGTH = 3'd5,
    REG_SAMPLES_PER_STEP  = 3'd6
  } gto_reg_t;

  typedef struct packed {
    logic [2:0]       swing_grid;
    logic [6:0]       swing_amount;
    logic [7:0]       pocket_amount;
    logic [6:0]       humanize_amount;
    logic [2:0]       quantize_grid;
    logic [6:0]       quantize_strength;
    logic [SPS_W-1:0] samples_per_step;
  } gto_cfg_t;

  localparam gto_cfg_t CFG_RST = '{
    swing_grid:        3'd1,
    swing_amount:      7'd0,
    pocket_amount:     8'd0,
    humanize_amount:   7'd0,
    quantize_grid:     3'd2,
    quantize_strength: 7'd0,
    samples_per_step:  '0
  };

  typedef struct packed {
    logic [NSTG-1:0] load;
  } gto_ctl_t;

  function automatic logic [6:0] sat_pct(input logic [6:0] v);
    return (v > 7'd100) ? 7'd100 : v;
  endfunction

  // grid period in sixths of a step
  function automatic logic [4:0] grid_sixths(input logic [2:0] code);
    logic [4:0] p;
    case (code)
      3'd0:    p = 5'd24;
      3'd1:    p = 5'd16;
      3'd2:    p = 5'd12;
      3'd3:    p = 5'd8;
      3'd4:    p = 5'd6;
      3'd5:    p = 5'd4;
      3'd6:    p = 5'd3;
      default: p = 5'd2;
    endcase
    return p;
  endfunction

  // 6 / period written as mul / 2^shift
  function automatic logic [1:0] grid_mul(input logic [2:0] code);
    logic [1:0] m;
    case (code)
      3'd0:    m = 2'd1;
      3'd1:    m = 2'd3;
      3'd2:    m = 2'd1;
      3'd3:    m = 2'd3;
      3'd4:    m = 2'd1;
      3'd5:    m = 2'd3;
      3'd6:    m = 2'd2;
      default: m = 2'd3;
    endcase
    return m;
  endfunction

  function automatic logic [1:0] grid_shift(input logic [2:0] code);
    logic [1:0] k;
    case (code)
      3'd0:    k = 2'd2;
      3'd1:    k = 2'd3;
      3'd2:    k = 2'd1;
      3'd3:    k = 2'd2;
      3'd4:    k = 2'd0;
      3'd5:    k = 2'd1;
      3'd6:    k = 2'd0;
      default: k = 2'd0;
    endcase
    return k;
  endfunction

  // metric weight 18*f/5*512, so the shift is |pk|*k / 15625 rounded
  function automatic logic [23:0] pocket_k(input logic [SLOT_W-1:0] slot);
    logic [23:0] k;
    if (slot == SLOT_W'(0))
      k = 24'd2764800;
    else if (slot == SLOT_W'(STEPS_PER_BAR / 2))
      k = 24'd4644864;
    else if (slot == SLOT_W'(STEPS_PER_BAR / 4) || slot == SLOT_W'(3 * STEPS_PER_BAR / 4))
      k = 24'd7464960;
    else if (!slot[0])
      k = 24'd9815040;
    else
      k = 24'd12165120;
    return k;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/core/gto_pipe_ctl.sv
// valid bits and per-stage load enables of the offset pipeline
// depends on gto_pkg
`default_nettype none

module gto_pipe_ctl
  import gto_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  output gto_ctl_t ctl
);

  logic [NSTG-1:0] vld_r;
  logic [NSTG-1:0] vld_nxt;
  logic [NSTG-1:0] load;

  // a stage takes new data when empty or when its content moves on
  always_comb begin
    load[NSTG-1] = !vld_r[NSTG-1] || out_ready;
    for (int i = NSTG - 2; i >= 0; i--) begin
      load[i] = !vld_r[i] || load[i+1];
    end
  end

  always_comb begin
    vld_nxt[0] = load[0] ? in_valid : vld_r[0];
    for (int i = 1; i < NSTG; i++) begin
      vld_nxt[i] = load[i] ? vld_r[i-1] : vld_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  assign in_ready  = load[0];
  assign out_valid = vld_r[NSTG-1];
  assign ctl.load  = load;

endmodule

`default_nettype wire

FILE: rtl/core/gto_shift_calc.sv
// stages 1 to 7: quantize, swing, pocket and humanize shifts summed in q16 steps
// depends on gto_pkg
`default_nettype none

module gto_shift_calc
  import gto_pkg::*;
(
  input  logic                    clk,
  input  gto_ctl_t                ctl,
  input  gto_cfg_t                cfg,
  input  logic signed [POS_W-1:0] pos,
  input  logic [ID_W-1:0]         note_id,
  output logic                    tot_neg,
  output logic [20:0]             tot_mag
);

  // config derived terms
  logic [6:0] qs, sw, hu, pk_mag;
  logic [7:0] pk_abs;
  logic       pk_neg;
  logic [2:0] g;
  logic [1:0] gm, gk;
  logic [4:0] p6;

  always_comb begin
    qs     = sat_pct(cfg.quantize_strength);
    sw     = sat_pct(cfg.swing_amount);
    hu     = sat_pct(cfg.humanize_amount);
    pk_neg = cfg.pocket_amount[7];
    pk_abs = pk_neg ? 8'(~cfg.pocket_amount + 8'd1) : cfg.pocket_amount;
    pk_mag = (pk_abs > 8'd100) ? 7'd100 : pk_abs[6:0];
    g      = (cfg.swing_grid > 3'd5) ? 3'd5 : cfg.swing_grid;
    gm     = grid_mul(cfg.quantize_grid);
    gk     = grid_shift(cfg.quantize_grid);
    p6     = grid_sixths(cfg.quantize_grid);
  end

  // stage 1: magnitude, hash product, swing size
  logic [POS_W-1:0] pos_u;
  logic [ID_W-1:0]  id_p1;
  logic [24:0]      sw_num;
  logic [50:0]      sw_prod;
  logic [POS_W-1:0] s1_pos_nxt, s1_mag_nxt;
  logic [ID_W-1:0]  s1_y_nxt;
  logic [20:0]      s1_swing_nxt;
  logic [POS_W-1:0] s1_pos_r, s1_mag_r;
  logic             s1_neg_r;
  logic [ID_W-1:0]  s1_y_r;
  logic [20:0]      s1_swing_r;

  always_comb begin
    pos_u        = pos;
    s1_pos_nxt   = pos_u;
    s1_mag_nxt   = pos_u[POS_W-1] ? (~pos_u + 1'b1) : pos_u;
    id_p1        = note_id + 32'd1;
    s1_y_nxt     = id_p1 * HASH_MUL;
    sw_num       = (25'(sw) << (5'(g) + 5'd13)) + 25'd12;
    sw_prod      = 51'(sw_num) * 51'(SW_DIV_RCP);
    s1_swing_nxt = sw_prod[SW_DIV_SH +: 21];
  end

  always_ff @(posedge clk) begin
    if (ctl.load[0]) begin
      s1_pos_r   <= s1_pos_nxt;
      s1_neg_r   <= pos_u[POS_W-1];
      s1_mag_r   <= s1_mag_nxt;
      s1_y_r     <= s1_y_nxt;
      s1_swing_r <= s1_swing_nxt;
    end
  end

  // stage 2: nearest grid index (low bits), metric slot, hash quotient
  logic [41:0]       nsum, nfull;
  logic [5:0]        s2_nlow_nxt;
  logic [19:0]       slot_rnd;
  logic [SLOT_W-1:0] s2_slot_nxt;
  logic [63:0]       hq_prod;
  logic [5:0]        s2_nlow_r;
  logic [SLOT_W-1:0] s2_slot_r;
  logic [22:0]       s2_hq_r;
  logic [ID_W-1:0]   s2_y_r;
  logic [21:0]       s2_poslo_r;
  logic [20:0]       s2_swing_r;

  always_comb begin
    nsum = (gm[0] ? 42'(s1_mag_r) : 42'd0) + (gm[1] ? (42'(s1_mag_r) << 1) : 42'd0)
         + (42'd1 << (5'(gk) + 5'd15));
    nfull       = nsum >> (5'(gk) + 5'd16);
    s2_nlow_nxt = s1_neg_r ? (6'd0 - nfull[5:0]) : nfull[5:0];
    // round to nearest step, only the position inside the bar matters
    slot_rnd    = s1_mag_r[19:0] + 20'h08000;
    s2_slot_nxt = s1_neg_r ? (SLOT_W'(0) - slot_rnd[16 +: SLOT_W]) : slot_rnd[16 +: SLOT_W];
    hq_prod     = 64'(s1_y_r) * 64'(H_MOD_RCP);
  end

  always_ff @(posedge clk) begin
    if (ctl.load[1]) begin
      s2_nlow_r  <= s2_nlow_nxt;
      s2_slot_r  <= s2_slot_nxt;
      s2_hq_r    <= hq_prod[H_MOD_SH +: 23];
      s2_y_r     <= s1_y_r;
      s2_poslo_r <= s1_pos_r[21:0];
      s2_swing_r <= s1_swing_r;
    end
  end

  // stage 3: grid distance mod 2^22 (always small), hash remainder, pocket product
  logic [21:0] s3_diff_nxt, pos6;
  logic [ID_W-1:0] hrem;
  logic [30:0] s3_pkx_nxt;
  logic [21:0] s3_diff_r;
  logic [9:0]  s3_h_r;
  logic [30:0] s3_pkx_r;
  logic [21:0] s3_poslo_r;
  logic [20:0] s3_swing_r;

  always_comb begin
    pos6        = 22'(s2_poslo_r * 3'd6);
    s3_diff_nxt = {6'(s2_nlow_r * p6), 16'd0} - pos6;
    hrem        = s2_y_r - 32'(32'(s2_hq_r) * 32'd1000);
    s3_pkx_nxt  = 31'(31'(pk_mag) * 31'(pocket_k(s2_slot_r))) + 31'd7812;
  end

  always_ff @(posedge clk) begin
    if (ctl.load[2]) begin
      s3_diff_r  <= s3_diff_nxt;
      s3_h_r     <= hrem[9:0];
      s3_pkx_r   <= s3_pkx_nxt;
      s3_poslo_r <= s2_poslo_r;
      s3_swing_r <= s2_swing_r;
    end
  end

  // stage 4: scale by percents, pocket quotient
  logic        dneg;
  logic [21:0] dabs;
  logic [26:0] s4_qx_nxt;
  logic [11:0] h2, v_u, vabs;
  logic        vneg;
  logic [16:0] vh;
  logic [29:0] s4_hux_nxt;
  logic [63:0] pk_prod;
  logic [26:0] s4_qx_r;
  logic        s4_dneg_r, s4_vneg_r;
  logic [29:0] s4_hux_r;
  logic [16:0] s4_pq_r;
  logic [21:0] s4_poslo_r;
  logic [20:0] s4_swing_r;

  always_comb begin
    dneg       = s3_diff_r[21];
    dabs       = dneg ? (~s3_diff_r + 1'b1) : s3_diff_r;
    s4_qx_nxt  = 27'(27'(dabs[19:0]) * 27'(qs)) + 27'd300;
    h2         = {1'b0, s3_h_r, 1'b0};
    v_u        = h2 - 12'd1000;
    vneg       = v_u[11];
    vabs       = vneg ? (12'd1000 - h2) : v_u;
    vh         = 17'(vabs[9:0]) * 17'(hu);
    s4_hux_nxt = ((30'(vh) << 3) + 30'(vh)) * 30'd1024 + 30'd7812;
    pk_prod    = 64'(s3_pkx_r) * 64'(P_DIV_RCP);
  end

  always_ff @(posedge clk) begin
    if (ctl.load[3]) begin
      s4_qx_r    <= s4_qx_nxt;
      s4_dneg_r  <= dneg;
      s4_hux_r   <= s4_hux_nxt;
      s4_vneg_r  <= vneg;
      s4_pq_r    <= pk_prod[P_DIV_SH +: 17];
      s4_poslo_r <= s3_poslo_r;
      s4_swing_r <= s3_swing_r;
    end
  end

  // stage 5: quantize and humanize quotients, pocket sign applied
  logic [63:0] q_prod, h_prod;
  logic [17:0] s5_pocket_nxt;
  logic [17:0] s5_qq_r;
  logic [16:0] s5_hq_r;
  logic [17:0] s5_pocket_r;
  logic        s5_dneg_r, s5_vneg_r;
  logic [21:0] s5_poslo_r;
  logic [20:0] s5_swing_r;

  always_comb begin
    q_prod        = 64'(s4_qx_r) * 64'(Q_DIV_RCP);
    h_prod        = 64'(s4_hux_r) * 64'(P_DIV_RCP);
    s5_pocket_nxt = pk_neg ? (18'd0 - 18'(s4_pq_r)) : 18'(s4_pq_r);
  end

  always_ff @(posedge clk) begin
    if (ctl.load[4]) begin
      s5_qq_r     <= q_prod[Q_DIV_SH +: 18];
      s5_hq_r     <= h_prod[P_DIV_SH +: 17];
      s5_pocket_r <= s5_pocket_nxt;
      s5_dneg_r   <= s4_dneg_r;
      s5_vneg_r   <= s4_vneg_r;
      s5_poslo_r  <= s4_poslo_r;
      s5_swing_r  <= s4_swing_r;
    end
  end

  // stage 6: swing slot test on the quantized position, partial sum
  logic [18:0] shq;
  logic [17:0] shh;
  logic [21:0] cur, s6_part_nxt;
  logic        s6_odd_nxt;
  logic [21:0] s6_part_r;
  logic        s6_odd_r;
  logic [20:0] s6_swing_r;

  always_comb begin
    shq         = s5_dneg_r ? (19'd0 - 19'(s5_qq_r)) : 19'(s5_qq_r);
    shh         = s5_vneg_r ? (18'd0 - 18'(s5_hq_r)) : 18'(s5_hq_r);
    cur         = s5_poslo_r + {{3{shq[18]}}, shq};
    s6_odd_nxt  = cur[5'(g) + 5'd16];
    s6_part_nxt = {{3{shq[18]}}, shq} + {{4{s5_pocket_r[17]}}, s5_pocket_r}
                + {{4{shh[17]}}, shh};
  end

  always_ff @(posedge clk) begin
    if (ctl.load[5]) begin
      s6_part_r  <= s6_part_nxt;
      s6_odd_r   <= s6_odd_nxt;
      s6_swing_r <= s5_swing_r;
    end
  end

  // stage 7: add swing, split into sign and magnitude
  logic [21:0] total, tabs;
  logic        s7_neg_r;
  logic [20:0] s7_mag_r;

  always_comb begin
    total = s6_part_r + (s6_odd_r ? {1'b0, s6_swing_r} : 22'd0);
    tabs  = total[21] ? (~total + 1'b1) : total;
  end

  always_ff @(posedge clk) begin
    if (ctl.load[6]) begin
      s7_neg_r <= total[21];
      s7_mag_r <= tabs[20:0];
    end
  end

  assign tot_neg = s7_neg_r;
  assign tot_mag = s7_mag_r;

endmodule

`default_nettype wire

FILE: rtl/core/gto_scale_sat.sv
// stages 8 and 9: scale steps to samples, round and saturate to 24 bits
// depends on gto_pkg
`default_nettype none

module gto_scale_sat
  import gto_pkg::*;
(
  input  logic                    clk,
  input  gto_ctl_t                ctl,
  input  logic [SPS_W-1:0]        sps,
  input  logic                    tot_neg,
  input  logic [20:0]             tot_mag,
  output logic signed [OUT_W-1:0] offset
);

  logic [52:0]      s8_prod_nxt;
  logic [52:0]      s8_prod_r;
  logic             s8_neg_r;
  logic [52:0]      rnd;
  logic [28:0]      smp;
  logic [OUT_W-1:0] s9_out_nxt;
  logic [OUT_W-1:0] s9_out_r;

  assign s8_prod_nxt = 53'(tot_mag) * 53'(sps);

  always_ff @(posedge clk) begin
    if (ctl.load[7]) begin
      s8_prod_r <= s8_prod_nxt;
      s8_neg_r  <= tot_neg;
    end
  end

  always_comb begin
    rnd = s8_prod_r + (53'd1 << 23);
    smp = rnd[52:24];
    if (s8_neg_r) begin
      s9_out_nxt = (smp > 29'd8388608) ? 24'h800000 : (24'd0 - smp[23:0]);
    end else begin
      s9_out_nxt = (smp > 29'd8388607) ? 24'h7FFFFF : smp[23:0];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load[8]) begin
      s9_out_r <= s9_out_nxt;
    end
  end

  assign offset = $signed(s9_out_r);

endmodule

`default_nettype wire

FILE: rtl/core/groove_timing_offset.sv
// Groove timing offset. Each note (position in sixteenth steps, signed Q23.16,
// and a note id) gets one timing offset in samples: partial quantize, swing,
// metric pocket and hashed humanize shifts are summed in Q16 steps, scaled by
// samples_per_step (Q24.8) and saturated to 24 bits. The datapath is a
// nine-stage pipeline with valid bits per stage; it takes one note per clock
// while the output is not held, and results leave stage nine in order.
// Backpressure only stalls stages that are full, so bubbles close up.
// Register writes are always taken (cfg_ready is tied high) and must only be
// made while no note is in flight.
// depends on gto_pkg, gto_pipe_ctl, gto_shift_calc, gto_scale_sat
`default_nettype none

module groove_timing_offset
  import gto_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic signed [POS_W-1:0] in_step_position,
  input  logic [ID_W-1:0]         in_note_id,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic signed [OUT_W-1:0] out_offset_samples,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [2:0]              cfg_index,
  input  logic [31:0]             cfg_data
);

  gto_cfg_t    cfg_r, cfg_nxt;
  gto_ctl_t    ctl;
  logic        tot_neg;
  logic [20:0] tot_mag;

  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_SWING_GRID:        cfg_nxt.swing_grid        = cfg_data[2:0];
        REG_SWING_AMOUNT:      cfg_nxt.swing_amount      = cfg_data[6:0];
        REG_POCKET_AMOUNT:     cfg_nxt.pocket_amount     = cfg_data[7:0];
        REG_HUMANIZE_AMOUNT:   cfg_nxt.humanize_amount   = cfg_data[6:0];
        REG_QUANTIZE_GRID:     cfg_nxt.quantize_grid     = cfg_data[2:0];
        REG_QUANTIZE_STRENGTH: cfg_nxt.quantize_strength = cfg_data[6:0];
        REG_SAMPLES_PER_STEP:  cfg_nxt.samples_per_step  = cfg_data;
        default:               cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= CFG_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  gto_pipe_ctl u_ctl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .ctl       (ctl)
  );

  gto_shift_calc u_calc (
    .clk     (clk),
    .ctl     (ctl),
    .cfg     (cfg_r),
    .pos     (in_step_position),
    .note_id (in_note_id),
    .tot_neg (tot_neg),
    .tot_mag (tot_mag)
  );

  gto_scale_sat u_scale (
    .clk     (clk),
    .ctl     (ctl),
    .sps     (cfg_r.samples_per_step),
    .tot_neg (tot_neg),
    .tot_mag (tot_mag),
    .offset  (out_offset_samples)
  );

endmodule

`default_nettype wire

FILE: rtl/core/gto_checker.sv
// port-level checks of the groove timing offset block, bound to the top level
// depends on gto_pkg and groove_timing_offset_defines.svh
`default_nettype none
`include "groove_timing_offset_defines.svh"

module gto_checker
  import gto_pkg::*;
(
  input logic                    clk,
  input logic                    rst_n,
  input logic                    in_ready,
  input logic                    out_valid,
  input logic                    out_ready,
  input logic signed [OUT_W-1:0] out_offset_samples,
  input logic                    cfg_valid,
  input logic                    cfg_ready,
  input logic [2:0]              cfg_index,
  input logic [31:0]             cfg_data
);

  // tracks whether samples per step is zero
  logic sps_zero_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sps_zero_r <= 1'b1;
    end else if (cfg_valid && cfg_ready && cfg_index == REG_SAMPLES_PER_STEP) begin
      sps_zero_r <= (cfg_data == 32'd0);
    end
  end

  `GTO_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_offset_samples), "result changed while stalled")
  `GTO_ASSERT_NOW(a_full_rate, out_ready || !out_valid, in_ready, "input blocked while output drains")
  `GTO_ASSERT_NOW(a_zero_scale, out_valid && sps_zero_r, out_offset_samples == '0, "nonzero offset with zero scale")
  `GTO_ASSERT_NOW(a_reset_empty, $rose(rst_n), !out_valid, "result present right after reset")

endmodule

bind groove_timing_offset gto_checker u_gto_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_ready           (in_ready),
  .out_valid          (out_valid),
  .out_ready          (out_ready),
  .out_offset_samples (out_offset_samples),
  .cfg_valid          (cfg_valid),
  .cfg_ready          (cfg_ready),
  .cfg_index          (cfg_index),
  .cfg_data           (cfg_data)
);

`default_nettype wire

FILE: verif/groove_timing_offset_tb.sv
// self-checking testbench for groove_timing_offset: directed table, then random phases
// drives notes with random idling, writes registers and checks every offset
// depends on gto_pkg and the groove_timing_offset rtl
`timescale 1ns / 1ps

module groove_timing_offset_tb;
  import gto_pkg::*;

  localparam int NUM_PHASES   = 14;
  localparam int PHASE_NOTES  = 60;
  localparam int TAIL_CYCLES  = 40;
  localparam int LIMIT_CYCLES = 200_000;
  localparam int DIR_ROWS     = 34;

  localparam logic signed [OUT_W-1:0] SAT_HI = 24'sh7F_FFFF;
  localparam logic signed [OUT_W-1:0] SAT_LO = 24'sh80_0000;
  localparam logic signed [POS_W-1:0] P_MAX  = 40'sh7F_FFFF_FFFF;
  localparam logic signed [POS_W-1:0] P_MIN  = 40'sh80_0000_0000;

  typedef enum logic [1:0] {
    ROW_CFG,
    ROW_NOTE,
    ROW_NOTE_FIXED
  } row_kind_t;

  typedef struct packed {
    row_kind_t               kind;
    gto_reg_t                reg_idx;
    logic [31:0]             data;
    logic signed [POS_W-1:0] pos;
    logic [ID_W-1:0]         id;
    logic signed [OUT_W-1:0] want;
  } dir_row_t;

  typedef struct packed {
    logic                    fixed;
    logic signed [OUT_W-1:0] value;
  } pending_note_t;

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    in_valid = 1'b0;
  logic                    in_ready;
  logic signed [POS_W-1:0] in_step_position = '0;
  logic [ID_W-1:0]         in_note_id = '0;
  logic                    out_valid;
  logic                    out_ready = 1'b0;
  logic signed [OUT_W-1:0] out_offset_samples;
  logic                    cfg_valid = 1'b0;
  logic                    cfg_ready;
  logic [2:0]              cfg_index = '0;
  logic [31:0]             cfg_data = '0;

  gto_cfg_t                live_cfg = CFG_RST;
  pending_note_t           pending_notes[$];
  logic signed [OUT_W-1:0] expected_offsets[$];
  pending_note_t           accepted_note;
  logic signed [OUT_W-1:0] want_offset;
  logic signed [OUT_W-1:0] next_offset;
  int                      mismatches = 0;
  bit                      tx_calm = 1'b0;
  bit                      rx_calm = 1'b0;

  // fixed rows are read straight off the register settings above them
  dir_row_t dir_table [DIR_ROWS] = '{
    '{ROW_NOTE_FIXED, REG_SWING_GRID, 32'h0, 40'sh0, 32'h0, 24'sh0},
    '{ROW_NOTE_FIXED, REG_SWING_GRID, 32'h0, P_MIN, 32'hFFFF_FFFF, 24'sh0},
    '{ROW_NOTE_FIXED, REG_SWING_GRID, 32'h0, P_MAX, 32'h0, 24'sh0},
    '{ROW_CFG, REG_SAMPLES_PER_STEP, 32'hFFFF_FFFF, 40'sh0, 32'h0, 24'sh0},
    '{ROW_CFG, REG_POCKET_AMOUNT, 32'h7F, 40'sh0, 32'h0, 24'sh0},
    '{ROW_NOTE_FIXED, REG_SWING_GRID, 32'h0, 40'sd65536, 32'd1, SAT_HI},
    '{ROW_NOTE_FIXED, REG_SWING_GRID, 32'h0, -40'sd983040, 32'd2, SAT_HI},
    '{ROW_NOTE, REG_SWING_GRID, 32'h0, P_MAX, 32'd3, 24'sh0},
    '{ROW_CFG, REG_POCKET_AMOUNT, 32'h80, 40'sh0, 32'h0, 24'sh0},
    '{ROW_NOTE_FIXED, REG_SWING_GRID, 32'h0, 40'sd65536, 32'd4, SAT_LO},
    '{ROW_CFG, REG_POCKET_AMOUNT, 32'h9C, 40'sh0, 32'h0, 24'sh0},
    '{ROW_CFG, REG_SAMPLES_PER_STEP, 32'h1800, 40'sh0, 32'h0, 24'sh0},
    '{ROW_NOTE, REG_SWING_GRID, 32'h0, 40'sd0, 32'd5, 24'sh0},
    '{ROW_NOTE, REG_SWING_GRID, 32'h0, 40'sd262144, 32'd6, 24'sh0},
    '{ROW_NOTE, REG_SWING_GRID, 32'h0, 40'sd524288, 32'd7, 24'sh0},
    '{ROW_NOTE, REG_SWING_GRID, 32'h0, 40'sd131072, 32'd8, 24'sh0},
    '{ROW_NOTE, REG_SWING_GRID, 32'h0, 40'sd196608, 32'd9, 24'sh0},
    '{ROW_NOTE, REG_SWING_GRID, 32'h0, 40'sd32768, 32'd10, 24'sh0},
    '{ROW_NOTE, REG_SWING_GRID, 32'h0, -40'sd32768, 32'd11, 24'sh0},
    '{ROW_CFG, REG_POCKET_AMOUNT, 32'h0, 40'sh0, 32'h0, 24'sh0},
    '{ROW_CFG, REG_QUANTIZE_STRENGTH, 32'h7F, 40'sh0, 32'h0, 24'sh0},
    '{ROW_CFG, REG_QUANTIZE_GRID, 32'h7, 40'sh0, 32'h0, 24'sh0},
    '{ROW_CFG, REG_SAMPLES_PER_STEP, 32'h0010_0000, 40'sh0, 32'h0, 24'sh0},
    '{ROW_NOTE, REG_SWING_GRID, 32'h0, 40'sd10923, 32'd12, 24'sh0},
    '{ROW_NOTE, REG_SWING_GRID, 32'h0, P_MAX, 32'd13, 24'sh0},
    '{ROW_NOTE, REG_SWING_GRID, 32'h0, P_MIN, 32'd14, 24'sh0},
    '{ROW_CFG, REG_QUANTIZE_GRID, 32'h1, 40'sh0, 32'h0, 24'sh0},
    '{ROW_CFG, REG_SWING_AMOUNT, 32'h7F, 40'sh0, 32'h0, 24'sh0},
    '{ROW_CFG, REG_SWING_GRID, 32'h7, 40'sh0, 32'h0, 24'sh0},
    '{ROW_CFG, REG_HUMANIZE_AMOUNT, 32'h7F, 40'sh0, 32'h0, 24'sh0},
    '{ROW_NOTE, REG_SWING_GRID, 32'h0, 40'sd2097152, 32'hFFFF_FFFF, 24'sh0},
    '{ROW_NOTE, REG_SWING_GRID, 32'h0, 40'sd2137152, 32'h0, 24'sh0},
    '{ROW_NOTE, REG_SWING_GRID, 32'h0, -40'sd1, 32'd12345, 24'sh0},
    '{ROW_NOTE, REG_SWING_GRID, 32'h0, 40'sd6291455, 32'h8000_0000, 24'sh0}
  };

  groove_timing_offset u_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_step_position   (in_step_position),
    .in_note_id         (in_note_id),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_offset_samples (out_offset_samples),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // division rounded half away from zero, den > 0
  function automatic longint round_div(input longint num, input longint den);
    if (num >= 0) begin
      return (num + den / 2) / den;
    end
    return -((-num + den / 2) / den);
  endfunction

  // grid period in sixths of a step
  function automatic longint grid_period(input logic [2:0] code);
    case (code)
      3'd0:    return 24;
      3'd1:    return 16;
      3'd2:    return 12;
      3'd3:    return 8;
      3'd4:    return 6;
      3'd5:    return 4;
      3'd6:    return 3;
      default: return 2;
    endcase
  endfunction

  function automatic logic signed [OUT_W-1:0] groove_offset(
    input gto_cfg_t c, input logic signed [POS_W-1:0] step_pos, input logic [ID_W-1:0] id);
    longint      pos, total, qs, sw, hu, pk, p6, n, diff, r, f, jit;
    int unsigned g;
    logic [63:0] cur, mag, smp;
    logic [31:0] h;
    logic [3:0]  slot;
    bit          neg;
    pos   = step_pos;
    total = 0;
    qs = (c.quantize_strength > 7'd100) ? 100 : longint'(c.quantize_strength);
    sw = (c.swing_amount > 7'd100) ? 100 : longint'(c.swing_amount);
    hu = (c.humanize_amount > 7'd100) ? 100 : longint'(c.humanize_amount);
    pk = longint'($signed(c.pocket_amount));
    if (pk > 100) pk = 100;
    if (pk < -100) pk = -100;
    g = (c.swing_grid > 3'd5) ? 5 : c.swing_grid;

    if (qs > 0) begin
      p6    = grid_period(c.quantize_grid);
      n     = round_div(pos * 6, p6 * 65536);
      diff  = n * p6 * 65536 - pos * 6;
      total += round_div(diff * qs, 600);
    end
    // odd slot test runs on the quantized position
    if (sw > 0) begin
      cur = pos + total;
      if (cur[16+g]) begin
        total += round_div(sw * (longint'(1) << g) * 65536, 200);
      end
    end
    // metric slot comes from the raw position, mod 16 on two's complement
    if (pk != 0) begin
      r    = round_div(pos, 65536);
      slot = r[3:0];
      if (slot == 0) f = 1500;
      else if (slot == STEPS_PER_BAR / 2) f = 2520;
      else if (slot == STEPS_PER_BAR / 4 || slot == 3 * STEPS_PER_BAR / 4) f = 4050;
      else if (!slot[0]) f = 5325;
      else f = 6600;
      total += round_div(pk * 18 * f * 65536, 10000000);
    end
    if (hu > 0) begin
      h     = (id + 32'd1) * 32'd2654435761;
      h     = h % 32'd1000;
      jit   = 2 * longint'(h) - 1000;
      total += round_div(jit * hu * 9 * 65536, 1000000);
    end

    neg = total < 0;
    mag = neg ? -total : total;
    smp = (mag * c.samples_per_step + (64'd1 << 23)) >> 24;
    if (neg) begin
      return (smp > 64'd8388608) ? SAT_LO : OUT_W'(-smp);
    end
    return (smp > 64'd8388607) ? SAT_HI : OUT_W'(smp);
  endfunction

  function automatic logic [6:0] rand_percent();
    int unsigned pick;
    pick = $urandom_range(0, 7);
    if (pick < 2) return 7'd0;
    if (pick == 2) return 7'($urandom_range(101, 127));
    return 7'($urandom_range(1, 100));
  endfunction

  // positions near grid and half-grid points, within +-256 steps of zero, or anywhere
  function automatic logic signed [POS_W-1:0] rand_position(input logic [2:0] qgrid);
    int unsigned style;
    longint      k;
    style = $urandom_range(0, 9);
    if (style == 0) return POS_W'({$urandom, $urandom});
    if (style < 5) begin
      k = longint'($urandom_range(0, 4000)) - 2000;
      return POS_W'(k * grid_period(qgrid) * 65536 / 12 + longint'($urandom_range(0, 8)) - 4);
    end
    return POS_W'(longint'($urandom_range(0, 32'h0200_0000)) - 64'sh0100_0000);
  endfunction

  function automatic logic [ID_W-1:0] rand_note_id();
    int unsigned pick;
    pick = $urandom_range(0, 15);
    if (pick == 0) return 32'hFFFF_FFFF;
    if (pick == 1) return 32'h0;
    return $urandom;
  endfunction

  task automatic report_mismatch(input string msg);
    mismatches++;
    $display("mismatch at %0t: %s", $time, msg);
  endtask

  task automatic write_reg(input gto_reg_t idx, input logic [31:0] val, input bit last);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    if (last) cfg_valid <= 1'b0;
  endtask

  task automatic send_note(input logic signed [POS_W-1:0] pos, input logic [ID_W-1:0] id,
                           input bit fixed, input logic signed [OUT_W-1:0] value);
    int unsigned   gap;
    pending_note_t entry;
    gap = tx_calm ? 0 : $urandom_range(0, 10);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_step_position <= pos;
    in_note_id       <= id;
    entry.fixed   = fixed;
    entry.value   = value;
    pending_notes = {pending_notes, entry};
    do @(posedge clk); while (!in_ready);
  endtask

  // every note yields an offset, so an empty queue means the pipe is empty
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_offsets.size() != 0) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (expected_offsets.size() == 0) begin
          report_mismatch($sformatf("offset %0d with nothing expected", out_offset_samples));
        end else begin
          want_offset = expected_offsets.pop_front();
          if (out_offset_samples !== want_offset) begin
            report_mismatch($sformatf("offset_samples got %0d want %0d",
                                      out_offset_samples, want_offset));
          end
        end
      end
      if (in_valid && in_ready && pending_notes.size() != 0) begin
        accepted_note = pending_notes.pop_front();
        next_offset = accepted_note.fixed ? accepted_note.value :
                      groove_offset(live_cfg, in_step_position, in_note_id);
        expected_offsets = {expected_offsets, next_offset};
      end
      if (cfg_valid && cfg_ready) begin
        case (gto_reg_t'(cfg_index))
          REG_SWING_GRID:        live_cfg.swing_grid        = cfg_data[2:0];
          REG_SWING_AMOUNT:      live_cfg.swing_amount      = cfg_data[6:0];
          REG_POCKET_AMOUNT:     live_cfg.pocket_amount     = cfg_data[7:0];
          REG_HUMANIZE_AMOUNT:   live_cfg.humanize_amount   = cfg_data[6:0];
          REG_QUANTIZE_GRID:     live_cfg.quantize_grid     = cfg_data[2:0];
          REG_QUANTIZE_STRENGTH: live_cfg.quantize_strength = cfg_data[6:0];
          REG_SAMPLES_PER_STEP:  live_cfg.samples_per_step  = cfg_data;
          default: ;
        endcase
      end
    end
  end

  // result side: random stall before each transfer, with calm stretches
  initial begin
    int unsigned stall;
    wait (rst_n);
    @(posedge clk);
    forever begin
      if ($urandom_range(0, 39) == 0) rx_calm = !rx_calm;
      stall = rx_calm ? 0 : $urandom_range(0, 10);
      if (stall != 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  initial begin
    int unsigned cycles;
    cycles = 0;
    while (cycles < LIMIT_CYCLES) begin
      @(posedge clk);
      cycles++;
    end
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    dir_row_t    row;
    gto_cfg_t    c;
    bit          last;
    int unsigned pick;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < DIR_ROWS; i++) begin
      row = dir_table[i];
      if (row.kind == ROW_CFG) begin
        if (i == 0 || dir_table[i-1].kind != ROW_CFG) settle();
        last = (i == DIR_ROWS - 1) || (dir_table[i+1].kind != ROW_CFG);
        write_reg(row.reg_idx, row.data, last);
      end else begin
        send_note(row.pos, row.id, row.kind == ROW_NOTE_FIXED, row.want);
      end
    end

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      settle();
      if (ph == 0) begin
        c = '{3'd0, 7'd0, 8'h80, 7'd0, 3'd0, 7'd0, 32'd0};
      end else if (ph == 1) begin
        c = '{3'd7, 7'd127, 8'h7F, 7'd127, 3'd7, 7'd127, 32'hFFFF_FFFF};
      end else if (ph == 2) begin
        c = '{3'd0, 7'd1, 8'hFF, 7'd1, 3'd0, 7'd1, 32'd1};
      end else begin
        c.swing_grid        = 3'($urandom_range(0, 7));
        c.swing_amount      = rand_percent();
        c.humanize_amount   = rand_percent();
        c.quantize_grid     = 3'($urandom_range(0, 7));
        c.quantize_strength = rand_percent();
        pick = $urandom_range(0, 7);
        if (pick < 2) c.pocket_amount = 8'h0;
        else if (pick == 2) c.pocket_amount = 8'($urandom_range(0, 255));
        else c.pocket_amount = 8'(int'($urandom_range(0, 200)) - 100);
        // mostly musical tempos, sometimes zero or far out of range
        pick = $urandom_range(0, 7);
        if (pick == 0) c.samples_per_step = 32'd0;
        else if (pick == 1) c.samples_per_step = $urandom;
        else if (pick == 2) c.samples_per_step = 32'hFFFF_FFFF;
        else c.samples_per_step = $urandom_range(32'h0008_0000, 32'h0120_0000);
      end
      write_reg(REG_SWING_GRID, 32'(c.swing_grid), 1'b0);
      write_reg(REG_SWING_AMOUNT, 32'(c.swing_amount), 1'b0);
      write_reg(REG_POCKET_AMOUNT, 32'(c.pocket_amount), 1'b0);
      write_reg(REG_HUMANIZE_AMOUNT, 32'(c.humanize_amount), 1'b0);
      write_reg(REG_QUANTIZE_GRID, 32'(c.quantize_grid), 1'b0);
      write_reg(REG_QUANTIZE_STRENGTH, 32'(c.quantize_strength), 1'b0);
      write_reg(REG_SAMPLES_PER_STEP, c.samples_per_step, 1'b1);
      tx_calm = ($urandom_range(0, 3) == 0);
      repeat (PHASE_NOTES) send_note(rand_position(c.quantize_grid), rand_note_id(), 1'b0, '0);
    end

    settle();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0 && expected_offsets.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+rtl/core
rtl/core/gto_pkg.sv
rtl/core/gto_pipe_ctl.sv
rtl/core/gto_shift_calc.sv
rtl/core/gto_scale_sat.sv
rtl/core/groove_timing_offset.sv
rtl/core/gto_checker.sv
verif/groove_timing_offset_tb.sv
